@@ rtl/core/lpsm_pkg.sv @@
`default_nettype none

package lpsm_pkg;

	localparam int unsigned LimitWidth = 20;
	localparam int unsigned AddrWidth  = 3;

	typedef enum logic [1:0] {
		CMD_PACKET  = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EV_TICK      = 3'd0,
		EV_UNIQUE    = 3'd1,
		EV_DUPLICATE = 3'd2,
		EV_MARKER    = 3'd3,
		EV_TIMEOUT   = 3'd4,
		EV_SILENCE   = 3'd5,
		EV_RESTART   = 3'd6,
		EV_SPARE     = 3'd7
	} event_t;

	localparam logic [AddrWidth-1:0] ADDR_LISTEN  = 3'd0;
	localparam logic [AddrWidth-1:0] ADDR_SILENCE = 3'd4;

	localparam logic [LimitWidth-1:0] LISTEN_RESET  = 20'd12000;
	localparam logic [LimitWidth-1:0] SILENCE_RESET = 20'd3000;

	localparam logic [31:0] MARKER_WORD = 32'hDEAD_BEEF;
	localparam logic [31:0] NO_SEQ      = 32'hFFFF_FFFF;
	localparam logic [7:0]  RSSI_LO_INIT = 8'h00;
	localparam logic [7:0]  RSSI_HI_INIT = 8'h80;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] head_word;
		logic [31:0] count_word;
		logic [7:0]  rssi_byte;
	} req_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic [31:0]        window_age;
		logic [31:0]        received;
		logic [31:0]        unique_count;
		logic [31:0]        duplicate_count;
		logic [31:0]        burst_count;
		logic [31:0]        expected_total;
		logic [31:0]        lost_count;
		logic signed [7:0]  rssi_low;
		logic signed [7:0]  rssi_high;
		logic signed [31:0] rssi_total;
		logic [15:0]        rssi_samples;
	} rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/lpsm_window.sv @@
`default_nettype none

module lpsm_window (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               step,
	input  lpsm_pkg::req_t                    item,
	input  wire [lpsm_pkg::LimitWidth-1:0]    listen_limit,
	input  wire [lpsm_pkg::LimitWidth-1:0]    silence_limit,
	output lpsm_pkg::rsp_t                    report
);
	import lpsm_pkg::*;

	typedef struct packed {
		logic [31:0] received;
		logic [31:0] unique_n;
		logic [31:0] duplicate_n;
		logic [31:0] previous_seq;
		logic [31:0] highest_seq;
		logic [31:0] burst_n;
		logic [31:0] expected_sum;
		logic [31:0] window_ms;
		logic [31:0] quiet_ms;
		logic [31:0] rssi_accum;
		logic [7:0]  rssi_lo;
		logic [7:0]  rssi_hi;
		logic [15:0] rssi_count;
	} win_state_t;

	function automatic win_state_t cleared();
		win_state_t s;
		s = '0;
		s.previous_seq = NO_SEQ;
		s.rssi_lo = RSSI_LO_INIT;
		s.rssi_hi = RSSI_HI_INIT;
		return s;
	endfunction

	win_state_t state_q;
	win_state_t post;
	win_state_t nxt;
	event_t     ev;
	logic [7:0] rpat;
	logic       is_dup;
	logic [31:0] total;

	always_comb begin
		rpat   = 8'(~item.rssi_byte + 8'd1);
		is_dup = (state_q.previous_seq != NO_SEQ) && (item.head_word == state_q.previous_seq);
		post   = state_q;
		nxt    = state_q;
		ev     = EV_TICK;
		case (cmd_t'(item.cmd))
			CMD_PACKET: begin
				post.rssi_accum = state_q.rssi_accum + {{24{rpat[7]}}, rpat};
				post.rssi_count = state_q.rssi_count + 16'd1;
				if ($signed(rpat) < $signed(state_q.rssi_lo)) post.rssi_lo = rpat;
				if ($signed(rpat) > $signed(state_q.rssi_hi)) post.rssi_hi = rpat;
				post.quiet_ms = '0;
				if (item.head_word == MARKER_WORD) begin
					post.burst_n      = state_q.burst_n + 32'd1;
					post.expected_sum = state_q.expected_sum + item.count_word;
					post.previous_seq = NO_SEQ;
					ev = EV_MARKER;
				end else begin
					post.received = state_q.received + 32'd1;
					if (is_dup) begin
						post.duplicate_n = state_q.duplicate_n + 32'd1;
						ev = EV_DUPLICATE;
					end else begin
						post.unique_n = state_q.unique_n + 32'd1;
						ev = EV_UNIQUE;
					end
					post.previous_seq = item.head_word;
					if (item.head_word > state_q.highest_seq) post.highest_seq = item.head_word;
				end
				nxt = post;
			end
			CMD_TICK: begin
				post.window_ms = state_q.window_ms + 32'd1;
				post.quiet_ms  = state_q.quiet_ms + 32'd1;
				if (post.window_ms >= {12'd0, listen_limit}) begin
					ev  = EV_TIMEOUT;
					nxt = cleared();
				end else if (state_q.received != '0
						&& post.quiet_ms >= {12'd0, silence_limit}) begin
					ev  = EV_SILENCE;
					nxt = cleared();
				end else begin
					nxt = post;
				end
			end
			CMD_RESTART: begin
				post = cleared();
				nxt  = post;
				ev   = EV_RESTART;
			end
			default: begin
				ev = EV_TICK;
			end
		endcase
	end

	// expected total prefers marker sum, then highest seq plus one
	always_comb begin
		if (post.expected_sum != '0) total = post.expected_sum;
		else if (post.highest_seq != '0) total = post.highest_seq + 32'd1;
		else total = '0;
		report.event_res       = ev;
		report.window_age      = post.window_ms;
		report.received        = post.received;
		report.unique_count    = post.unique_n;
		report.duplicate_count = post.duplicate_n;
		report.burst_count     = post.burst_n;
		report.expected_total  = total;
		report.lost_count      = (total > post.received) ? total - post.received : '0;
		report.rssi_low        = post.rssi_lo;
		report.rssi_high       = post.rssi_hi;
		report.rssi_total      = post.rssi_accum;
		report.rssi_samples    = post.rssi_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cleared();
		end else if (step) begin
			state_q <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/link_packet_statistics_monitor.sv @@
`default_nettype none

// Receive-window link statistics. Each item on req is a packet (with head word,
// count word and RSSI status byte), a one millisecond tick or a window restart,
// and produces exactly one result on rsp with the window counters after that
// item; on a timeout or silence end the result carries the ended window's
// totals and the window clears. Items pass through an input register and a
// result register, with all state updated as an item moves between them, so
// one item per cycle is sustained while rsp_ready stays high. Limits are
// written over the APB port at 0x0 (listen) and 0x4 (silence).
module link_packet_statistics_monitor (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              req_valid,
	output logic                             req_ready,
	input  lpsm_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  wire                              rsp_ready,
	output lpsm_pkg::rsp_t                   rsp,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [lpsm_pkg::AddrWidth-1:0]    paddr,
	input  wire [31:0]                       pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import lpsm_pkg::*;

	logic [LimitWidth-1:0] listen_q;
	logic [LimitWidth-1:0] silence_q;
	logic                  valid_s1;
	req_t                  item_s1;
	logic                  move;
	rsp_t                  report;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_q  <= LISTEN_RESET;
			silence_q <= SILENCE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				ADDR_LISTEN:  listen_q  <= pwdata[LimitWidth-1:0];
				ADDR_SILENCE: silence_q <= pwdata[LimitWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_LISTEN:  prdata = {12'd0, listen_q};
			ADDR_SILENCE: prdata = {12'd0, silence_q};
			default:      prdata = '0;
		endcase
	end

	assign move      = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (req_ready) valid_s1 <= req_valid;
			if (move) rsp_valid <= 1'b1;
			else if (rsp_ready) rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) item_s1 <= req;
		if (move) rsp <= report;
	end

	lpsm_window u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (move),
		.item          (item_s1),
		.listen_limit  (listen_q),
		.silence_limit (silence_q),
		.report        (report)
	);

endmodule

`default_nettype wire
